// ===== hdl/esud_pkg.sv =====
// Shared types and constants for the escape sequence UTF-8 decoder.
`default_nettype none

package esud_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [2:0] StatOk         = 3'd0;
  localparam logic [2:0] StatUnknownEsc = 3'd1;
  localparam logic [2:0] StatShortHex   = 3'd2;
  localparam logic [2:0] StatNonAlnum   = 3'd3;
  localparam logic [2:0] StatDigitOverF = 3'd4;
  localparam logic [2:0] StatUnencodable = 3'd5;

  // One decoded input transaction: 0..4 bytes plus optional end marker.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic [2:0]      status;
    logic            eos;
  } job_t;

endpackage : esud_pkg

`default_nettype wire

// ===== hdl/esud_front.sv =====
// Front end: escape and hex parsing, UTF-8 encoding, at most one job per transaction.
`default_nettype none

module esud_front
  import esud_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_only_i,
  input  wire logic       last_item_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output job_t            q_job_o
);

  localparam logic [1:0] PhNormal = 2'd0;
  localparam logic [1:0] PhEscape = 2'd1;
  localparam logic [1:0] PhHex    = 2'd2;
  localparam logic [1:0] PhError  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  hex_cnt_q, hex_cnt_d;
  logic        hex_wide_q, hex_wide_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  bad_q, bad_d;
  logic [2:0]  err_q, err_d;

  logic        accept;
  logic        last;
  logic [7:0]  lc;
  logic        is_dig, is_alpha;
  logic [3:0]  dval;
  logic [31:0] cp;
  logic [3:0]  cnt_inc;
  logic [3:0]  need;
  logic [2:0]  status;
  job_t        job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = end_only_i || last_item_i;

  assign lc       = in_byte_i | 8'h20;
  assign is_dig   = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign is_alpha = (lc >= 8'h61) && (lc <= 8'h7a);
  assign dval     = is_dig ? in_byte_i[3:0] : (is_alpha ? 4'(lc - 8'h57) : 4'h0);
  assign cp       = {acc_q[27:0], dval};
  assign cnt_inc  = hex_cnt_q + 4'd1;
  assign need     = hex_wide_q ? 4'd8 : 4'd4;

  always_comb begin
    phase_d    = phase_q;
    hex_cnt_d  = hex_cnt_q;
    hex_wide_d = hex_wide_q;
    acc_d      = acc_q;
    bad_d      = bad_q;
    err_d      = err_q;
    job        = '0;
    status     = StatOk;

    if (!end_only_i) begin
      unique case (phase_q)
        PhNormal: begin
          if (in_byte_i == 8'h5c) begin
            phase_d = PhEscape;
          end else begin
            job.bytes[0] = in_byte_i;
            job.cnt      = 3'd1;
          end
        end
        PhEscape: begin
          job.cnt = 3'd1;
          phase_d = PhNormal;
          unique case (in_byte_i) inside
            8'h61: job.bytes[0] = 8'h07;
            8'h62: job.bytes[0] = 8'h08;
            8'h66: job.bytes[0] = 8'h0c;
            8'h6e: job.bytes[0] = 8'h0a;
            8'h72: job.bytes[0] = 8'h0d;
            8'h74: job.bytes[0] = 8'h09;
            8'h76: job.bytes[0] = 8'h0b;
            8'h22: job.bytes[0] = 8'h22;
            8'h5c: job.bytes[0] = 8'h5c;
            8'h75, 8'h55: begin
              job.cnt    = 3'd0;
              phase_d    = PhHex;
              hex_wide_d = in_byte_i[5] == 1'b0;
              hex_cnt_d  = 4'd0;
              acc_d      = '0;
              bad_d      = 2'd0;
            end
            default: begin
              job.cnt = 3'd0;
              phase_d = PhError;
              err_d   = StatUnknownEsc;
            end
          endcase
        end
        PhHex: begin
          if (bad_q == 2'd0) begin
            if (!is_dig && !is_alpha) begin
              bad_d = 2'd1;
            end else if (is_alpha && lc > 8'h66) begin
              bad_d = 2'd2;
            end
          end
          acc_d     = cp;
          hex_cnt_d = cnt_inc;
          if (cnt_inc >= need) begin
            if (bad_d != 2'd0) begin
              phase_d = PhError;
              err_d   = {1'b0, bad_d} + 3'd2;
            end else if ((cp >= 32'h0000d800 && cp <= 32'h0000dfff) ||
                         cp > 32'h0010ffff) begin
              phase_d = PhError;
              err_d   = StatUnencodable;
            end else begin
              phase_d   = PhNormal;
              hex_cnt_d = 4'd0;
              acc_d     = '0;
              if (cp <= 32'h0000007f) begin
                job.cnt      = 3'd1;
                job.bytes[0] = cp[7:0];
              end else if (cp <= 32'h000007ff) begin
                job.cnt      = 3'd2;
                job.bytes[0] = {3'b110, cp[10:6]};
                job.bytes[1] = {2'b10, cp[5:0]};
              end else if (cp <= 32'h0000ffff) begin
                job.cnt      = 3'd3;
                job.bytes[0] = {4'b1110, cp[15:12]};
                job.bytes[1] = {2'b10, cp[11:6]};
                job.bytes[2] = {2'b10, cp[5:0]};
              end else begin
                job.cnt      = 3'd4;
                job.bytes[0] = {5'b11110, cp[20:18]};
                job.bytes[1] = {2'b10, cp[17:12]};
                job.bytes[2] = {2'b10, cp[11:6]};
                job.bytes[3] = {2'b10, cp[5:0]};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (last) begin
      unique case (phase_d)
        PhError:  status = err_d;
        PhEscape: status = StatUnknownEsc;
        PhHex:    status = StatShortHex;
        default:  status = StatOk;
      endcase
      job.status = status;
      job.eos    = 1'b1;
      phase_d    = PhNormal;
      hex_cnt_d  = 4'd0;
      hex_wide_d = 1'b0;
      acc_d      = '0;
      bad_d      = 2'd0;
      err_d      = StatOk;
    end
  end

  assign q_push_o = accept && ((job.cnt != 3'd0) || last);
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhNormal;
      hex_cnt_q  <= 4'd0;
      hex_wide_q <= 1'b0;
      acc_q      <= '0;
      bad_q      <= 2'd0;
      err_q      <= StatOk;
    end else if (accept) begin
      phase_q    <= phase_d;
      hex_cnt_q  <= hex_cnt_d;
      hex_wide_q <= hex_wide_d;
      acc_q      <= acc_d;
      bad_q      <= bad_d;
      err_q      <= err_d;
    end
  end

endmodule : esud_front

`default_nettype wire

// ===== hdl/esud_queue.sv =====
// Short job queue between front end and output serializer.
`default_nettype none

module esud_queue
  import esud_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output job_t      head_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == QueueCntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule : esud_queue

`default_nettype wire

// ===== hdl/esud_back.sv =====
// Back end: serializes each queued job into one result transaction per byte, or one byte-less end transaction.
`default_nettype none

module esud_back
  import esud_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  wire job_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [2:0] status_o,
  output logic       eos_o
);

  logic [1:0] idx_q;
  logic [1:0] last_idx;
  logic       is_last;
  logic       fire;

  assign last_idx     = (head_i.cnt == 3'd0) ? 2'd0 : 2'(head_i.cnt - 3'd1);
  assign is_last      = idx_q == last_idx;
  assign out_valid_o  = !empty_i;
  assign fire         = out_valid_o && out_ready_i;
  assign pop_o        = fire && is_last;

  assign byte_valid_o = head_i.cnt != 3'd0;
  assign out_byte_o   = byte_valid_o ? head_i.bytes[idx_q] : 8'h00;
  assign eos_o        = is_last && head_i.eos;
  assign status_o     = eos_o ? head_i.status : StatOk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule : esud_back

`default_nettype wire

// ===== hdl/escape_sequence_utf8_decoder.sv =====
// Top level of the string unescaper with UTF-8 encoding of \u and \U escapes.
//
// Input stream: one raw string-body byte per transaction on s_axis. tlast ends
// the string after the byte; tuser marks an end-only transaction whose byte
// is ignored.
// Output stream: one decoded byte per transaction on m_axis. tuser says the
// byte is present; tlast marks the final transaction of a string, and then
// tdata[10:8] carries the status (0 ok, 1..5 error). On an error, downstream
// drops the bytes of that string already delivered.
// Each input's job is written into the registered job queue and read from its head.
// Throughput: one input per cycle while the job queue (4 entries) has room;
// the output side moves one byte per cycle while m_axis is ready, so a code
// point that encodes to k bytes occupies the output for k transfers and
// backpressures input only once the queue fills.
// Reset clears the parse state and empties the queue. When m_axis stalls,
// the front end keeps accepting until the queue is full.
`default_nettype none

module escape_sequence_utf8_decoder
  import esud_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  wire logic        s_axis_tuser,  // [0] end_only
  input  wire logic        s_axis_tlast,  // last_item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [7:0] out_byte, [10:8] status
  output logic             m_axis_tuser,  // [0] byte_valid
  output logic             m_axis_tlast   // end_of_string
);

  logic       q_full, q_empty, q_push, q_pop;
  job_t       push_job, head_job;
  logic [7:0] out_byte;
  logic [2:0] status;

  esud_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .end_only_i  (s_axis_tuser),
    .last_item_i (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  esud_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  esud_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head_job),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .byte_valid_o (m_axis_tuser),
    .status_o     (status),
    .eos_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, status, out_byte};

endmodule : escape_sequence_utf8_decoder

`default_nettype wire

// ===== bench/escape_sequence_utf8_decoder_tb.sv =====
// Self-checking testbench for the escape sequence UTF-8 decoder (directed and random strings).
`default_nettype none

module escape_sequence_utf8_decoder_tb;
  import esud_pkg::*;

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] Quote     = 8'h22;

  typedef enum logic [1:0] {ScanPlain, ScanEscape, ScanHex, ScanError} scan_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [2:0] stat;
    logic       eos;
  } decoded_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;   // [0] end_only
  logic        s_axis_tlast = 1'b0;   // last_item
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] out_byte, [10:8] status
  logic        m_axis_tuser;          // [0] byte_valid
  logic        m_axis_tlast;          // end_of_string

  // decoder model state
  scan_e       scan_st = ScanPlain;
  logic [3:0]  hex_cnt = 4'd0;
  logic        hex_wide = 1'b0;
  logic [31:0] code_acc = 32'd0;
  logic [2:0]  bad_hex = StatOk;
  logic [2:0]  err_stat = StatOk;

  decoded_t    decoded_q[$];
  decoded_t    front_exp;
  logic [7:0]  str_q[$];
  int          n_errors = 0;
  int          items_sent = 0;
  int          src_gap_pct = 0;
  int          snk_gap_pct = 0;
  int unsigned snk_hold = 0;

  escape_sequence_utf8_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void put_byte(logic [7:0] b);
    decoded_q.push_back('{data: b, valid: 1'b1, stat: StatOk, eos: 1'b0});
  endfunction

  // Expected output transactions caused by one input transaction.
  function automatic void unescape_step(logic [7:0] c, logic eo, logic lst);
    int          n;
    int          d;
    logic [7:0]  ev;
    logic [2:0]  stat;
    logic [31:0] cp;
    n = 0;
    if (!eo) begin
      case (scan_st)
        ScanPlain: begin
          if (c == Backslash) begin
            scan_st = ScanEscape;
          end else begin
            put_byte(c);
            n = 1;
          end
        end
        ScanEscape: begin
          scan_st = ScanPlain;
          n = 1;
          ev = 8'h00;
          case (c) inside
            "a": ev = 8'h07;
            "b": ev = 8'h08;
            "f": ev = 8'h0C;
            "n": ev = 8'h0A;
            "r": ev = 8'h0D;
            "t": ev = 8'h09;
            "v": ev = 8'h0B;
            Quote: ev = Quote;
            Backslash: ev = Backslash;
            "u", "U": begin
              n = 0;
              scan_st = ScanHex;
              hex_wide = (c == "U");
              hex_cnt = 4'd0;
              code_acc = 32'd0;
              bad_hex = StatOk;
            end
            default: begin
              n = 0;
              scan_st = ScanError;
              err_stat = StatUnknownEsc;
            end
          endcase
          if (n == 1) put_byte(ev);
        end
        ScanHex: begin
          d = 0;
          if (c >= "0" && c <= "9") begin
            d = int'(c) - int'("0");
          end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
            d = int'(c | 8'h20) - int'("a") + 10;
          end else if (bad_hex == StatOk) begin
            bad_hex = StatNonAlnum;
          end
          if (d >= 16 && bad_hex == StatOk) bad_hex = StatDigitOverF;
          code_acc = {code_acc[27:0], 4'(d)};
          hex_cnt = hex_cnt + 4'd1;
          if (hex_cnt >= (hex_wide ? 4'd8 : 4'd4)) begin
            cp = code_acc;
            if (bad_hex != StatOk) begin
              scan_st = ScanError;
              err_stat = bad_hex;
            end else if ((cp >= 32'hD800 && cp <= 32'hDFFF) || cp > 32'h10FFFF) begin
              scan_st = ScanError;
              err_stat = StatUnencodable;
            end else begin
              scan_st = ScanPlain;
              hex_cnt = 4'd0;
              code_acc = 32'd0;
              if (cp <= 32'h7F) begin
                put_byte(cp[7:0]);
                n = 1;
              end else if (cp <= 32'h7FF) begin
                put_byte(8'hC0 | 8'(cp >> 6));
                put_byte(8'h80 | 8'(cp & 32'h3F));
                n = 2;
              end else if (cp <= 32'hFFFF) begin
                put_byte(8'hE0 | 8'(cp >> 12));
                put_byte(8'h80 | 8'((cp >> 6) & 32'h3F));
                put_byte(8'h80 | 8'(cp & 32'h3F));
                n = 3;
              end else begin
                put_byte(8'hF0 | 8'(cp >> 18));
                put_byte(8'h80 | 8'((cp >> 12) & 32'h3F));
                put_byte(8'h80 | 8'((cp >> 6) & 32'h3F));
                put_byte(8'h80 | 8'(cp & 32'h3F));
                n = 4;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (eo || lst) begin
      case (scan_st)
        ScanError:  stat = err_stat;
        ScanEscape: stat = StatUnknownEsc;
        ScanHex:    stat = StatShortHex;
        default:    stat = StatOk;
      endcase
      if (n == 0) begin
        decoded_q.push_back('{data: 8'h00, valid: 1'b0, stat: stat, eos: 1'b1});
      end else begin
        decoded_q[decoded_q.size() - 1].stat = stat;
        decoded_q[decoded_q.size() - 1].eos = 1'b1;
      end
      scan_st = ScanPlain;
      hex_cnt = 4'd0;
      hex_wide = 1'b0;
      code_acc = 32'd0;
      bad_hex = StatOk;
      err_stat = StatOk;
    end
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return "0" + 8'(v);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] esc_char(int i);
    case (i)
      0: return "a";
      1: return "b";
      2: return "f";
      3: return "n";
      4: return "r";
      5: return "t";
      6: return "v";
      7: return Quote;
      default: return Backslash;
    endcase
  endfunction

  // Code point of a given UTF-8 length class, often at a class boundary.
  function automatic logic [31:0] pick_code(int cls);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] v;
    case (cls)
      0: begin lo = 32'h0;     hi = 32'h7F;     end
      1: begin lo = 32'h80;    hi = 32'h7FF;    end
      2: begin lo = 32'h800;   hi = 32'hFFFF;   end
      default: begin lo = 32'h10000; hi = 32'h10FFFF; end
    endcase
    case ($urandom_range(0, 5))
      0: v = lo;
      1: v = hi;
      default: v = $urandom_range(hi, lo);
    endcase
    if (v >= 32'hD800 && v <= 32'hDFFF) v = v ^ 32'h1000;
    return v;
  endfunction

  function automatic void push_code(logic [31:0] cp, logic wide);
    str_q.push_back(Backslash);
    str_q.push_back(wide ? "U" : "u");
    for (int i = (wide ? 7 : 3); i >= 0; i--) str_q.push_back(hex_char(cp[i*4 +: 4]));
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic send_item(logic [7:0] b, logic eo, logic lst);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eo;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    unescape_step(b, eo, lst);
    items_sent++;
  endtask

  // Sends the built string, ended by tlast on its last byte or by an end-only transaction.
  task automatic send_body(bit end_by_marker);
    if (str_q.size() == 0) end_by_marker = 1'b1;
    foreach (str_q[i]) send_item(str_q[i], 1'b0, !end_by_marker && i == str_q.size() - 1);
    if (end_by_marker) send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
    str_q.delete();
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  task automatic test_plain_bytes();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b1);
    send_item(8'h5A, 1'b1, 1'b0);
  endtask

  task automatic test_simple_escapes();
    push_str("\\a\\b\\f\\n\\r\\t\\v\\\"\\\\");
    send_body(1'b0);
  endtask

  task automatic test_code_points();
    push_str("\\U0010FFFF");
    send_body(1'b1);
  endtask

  task automatic test_error_cases();
    push_str("\\");
    send_body(1'b0);
    push_str("\\qz");
    send_body(1'b1);
    push_str("\\uF");
    send_body(1'b1);
    push_str("\\u");
    str_q.push_back(8'h80);
    push_str("g00");
    send_body(1'b0);
    push_str("\\uDFFF");
    send_body(1'b1);
  endtask

  // Mostly well-formed strings with random content, plus broken escapes and noise.
  task automatic test_random_strings(int n_items, int gap_pct);
    int         stop_at;
    int         ntok;
    int         r;
    int         slot;
    bit         wide;
    bit         cut;
    logic [7:0] b;
    stop_at = items_sent + n_items;
    src_gap_pct = gap_pct;
    snk_gap_pct = gap_pct;
    while (items_sent < stop_at) begin
      ntok = $urandom_range(0, 6);
      cut = 1'b0;
      for (int k = 0; k < ntok && !cut; k++) begin
        r = $urandom_range(0, 99);
        wide = 1'($urandom_range(0, 1));
        if (r < 35) begin
          b = 8'($urandom_range(0, 255));
          str_q.push_back(b);
          if (b == Backslash) str_q.push_back(Backslash);
        end else if (r < 55) begin
          str_q.push_back(Backslash);
          str_q.push_back(esc_char($urandom_range(0, 8)));
        end else if (r < 70) begin
          push_code(pick_code($urandom_range(0, 2)), 1'b0);
        end else if (r < 82) begin
          push_code(pick_code($urandom_range(0, 3)), 1'b1);
        end else if (r < 87) begin
          push_code($urandom(), wide);
        end else if (r < 91) begin
          push_code($urandom_range(32'hDFFF, 32'hD800), wide);
        end else if (r < 95) begin
          push_code(pick_code($urandom_range(0, 2)), wide);
          slot = $urandom_range(1, wide ? 8 : 4);
          str_q[str_q.size() - slot] = 8'($urandom_range(0, 255));
        end else if (r < 98) begin
          str_q.push_back(Backslash);
          str_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          push_code(pick_code($urandom_range(0, 3)), wide);
          repeat ($urandom_range(1, wide ? 9 : 5)) void'(str_q.pop_back());
          cut = 1'b1;
        end
      end
      send_body($urandom_range(0, 3) == 0);
    end
  endtask

  always @(posedge clk_i) begin
    if (snk_hold != 0) begin
      snk_hold--;
    end else if ($urandom_range(0, 99) < snk_gap_pct) begin
      snk_hold = $urandom_range(1, 17);
    end
    m_axis_tready <= (snk_hold == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("transaction with nothing expected", m_axis_tdata, 16'h0000);
      end else begin
        front_exp = decoded_q.pop_front();
        if (m_axis_tdata[7:0] !== front_exp.data)
          report_mismatch("out_byte", 16'(m_axis_tdata[7:0]), 16'(front_exp.data));
        if (m_axis_tdata[10:8] !== front_exp.stat)
          report_mismatch("status", 16'(m_axis_tdata[10:8]), 16'(front_exp.stat));
        if (m_axis_tdata[15:11] !== 5'd0)
          report_mismatch("tdata padding", 16'(m_axis_tdata[15:11]), 16'h0000);
        if (m_axis_tuser !== front_exp.valid)
          report_mismatch("byte_valid", 16'(m_axis_tuser), 16'(front_exp.valid));
        if (m_axis_tlast !== front_exp.eos)
          report_mismatch("end_of_string", 16'(m_axis_tlast), 16'(front_exp.eos));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_gap_pct = 10;
    snk_gap_pct = 10;
    test_plain_bytes();
    test_simple_escapes();
    test_code_points();
    test_error_cases();
    wait_for_results();
    test_random_strings(120, 12);
    wait_for_results();
    test_random_strings(90, 0);
    test_random_strings(90, 35);
    test_random_strings(60, 0);
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("escape_sequence_utf8_decoder_tb passed");
    end else begin
      $display("escape_sequence_utf8_decoder_tb failed");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("escape_sequence_utf8_decoder_tb failed");
    $finish;
  end

endmodule : escape_sequence_utf8_decoder_tb

`default_nettype wire
